/* hw/rtl/pid_controller_clamped_assert.svh */
// Assertion macros for the clamped PID controller.
// Included by the top level; needs nothing else.
`ifndef PID_CONTROLLER_CLAMPED_ASSERT_SVH
`define PID_CONTROLLER_CLAMPED_ASSERT_SVH

// Check a consequence in the same cycle as its antecedent.
`define PCC_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define PCC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/pcc_pkg.sv */
// Shared constants and codes for the clamped PID controller.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package pcc_pkg;

	// Default widths
	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int TIME_WIDTH     = 32;

	// Timing constants
	localparam int STEP_MS  = 10;
	localparam int MS_PER_S = 1000;

	// Configuration register indexes
	localparam int CFG_IDX_W = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN   = 4'd0,
		REG_INTEG_GAIN  = 4'd1,
		REG_DERIV_GAIN  = 4'd2,
		REG_OUT_LOW     = 4'd3,
		REG_OUT_HIGH    = 4'd4,
		REG_INTEG_LOW   = 4'd5,
		REG_INTEG_HIGH  = 4'd6,
		REG_INTEG_START = 4'd7
	} cfg_reg_t;

	// Operations run on the shared multiply/divide unit
	typedef enum logic [2:0] {
		OP_P  = 3'd0,
		OP_I1 = 3'd1,
		OP_I2 = 3'd2,
		OP_D1 = 3'd3,
		OP_D2 = 3'd4
	} op_t;

endpackage

`default_nettype wire

/* hw/rtl/pcc_channels.sv */
// Valid/ready channel interfaces of the clamped PID controller.
// Depends on pcc_pkg for default widths and the register index width.
`default_nettype none

// Sample channel: setpoint, measurement and timestamp
interface pcc_sample_if import pcc_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] setpoint;
	logic signed [DATA_WIDTH-1:0] measured;
	logic        [TIME_WIDTH-1:0] now_ms;

	modport source (output valid, output setpoint, output measured, output now_ms,
		input ready);
	modport sink (input valid, input setpoint, input measured, input now_ms,
		output ready);
endinterface

// Result channel: drive value and step flag
interface pcc_result_if import pcc_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] drive;
	logic                         updated;

	modport source (output valid, output drive, output updated, input ready);
	modport sink (input valid, input drive, input updated, output ready);
endinterface

// Configuration write channel
interface pcc_cfg_if import pcc_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [DATA_WIDTH-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/pid_controller_clamped.sv */
// Clamped PID controller, signed fixed point, one shared shift-add/restoring unit.
// Depends on pcc_pkg, pcc_channels.sv and pid_controller_clamped_assert.svh.
//
//  channel | dir | payload                        | word accepted when
//  --------+-----+--------------------------------+---------------------
//  sample  | in  | setpoint, measured, now_ms     | valid && ready
//  result  | out | drive, updated                 | valid && ready
//  cfg     | in  | index, data                    | valid && ready (ready is always 1)
//
// A held sample (10 ms or less since the last step) skips the step and goes straight
// to the done state. A step runs five products on one serial multiplier, one bit per
// cycle over MB = max(DATA_WIDTH, 32) bits, two of them followed by a restoring divide
// that yields a DATA_WIDTH-bit quotient. The first step runs only the first three
// products, as it has no derivative term. A divide whose quotient would overflow is
// skipped, which shortens the step. sample.ready is high only while the sequencer is
// idle; the result register lets the next sample in while a result waits. Reset is
// asynchronous and needs no clearing pass.
`default_nettype none

`include "pid_controller_clamped_assert.svh"

module pid_controller_clamped import pcc_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	pcc_sample_if.sink    sample,
	pcc_result_if.source  result,
	pcc_cfg_if.sink       cfg
);

	localparam int DW = DATA_WIDTH;
	localparam int FW = FRAC_BITS;
	localparam int TW = TIME_WIDTH;
	localparam int MA = DW + 1;
	localparam int MB = (DW > TW) ? DW : TW;
	localparam int PW = MA + MB;
	localparam int CW = $clog2(MB);

	localparam logic signed [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_LOAD  = 8'b0000_0010,
		ST_MUL   = 8'b0000_0100,
		ST_DIV   = 8'b0000_1000,
		ST_FIN   = 8'b0001_0000,
		ST_INTEG = 8'b0010_0000,
		ST_SUM   = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

	// Sequencer and control state
	state_t                state_q;
	op_t                   op_q;
	logic [CW-1:0]         cnt_q;
	logic                  res_valid_q;

	// Configuration registers
	logic signed [DW-1:0]  prop_gain_q, integ_gain_q, deriv_gain_q;
	logic signed [DW-1:0]  out_low_q, out_high_q, integ_low_q, integ_high_q;

	// Controller state
	logic signed [DW-1:0]  integ_q, prev_meas_q, held_q;
	logic [TW-1:0]         prev_time_q;
	logic                  primed_q;

	// Working registers
	logic signed [DW:0]    err_q, diff_q;
	logic [TW-1:0]         elapsed_q;
	logic signed [DW-1:0]  p_q, inc_q, d_q;
	logic [MA-1:0]         mca_q;
	logic [PW-1:0]         prod_q;
	logic                  neg_q, ovf_q;
	logic [TW-1:0]         rem_q;
	logic [DW-1:0]         quo_q;
	logic signed [DW-1:0]  fin_drive_q, res_drive_q;
	logic                  fin_updated_q, res_updated_q;

	// Handshakes
	logic in_fire, out_fire, cfg_fire, res_load;
	logic [TW-1:0] elapsed_in;
	logic step_in;

	assign sample.ready   = (state_q == ST_IDLE);
	assign in_fire        = sample.valid && sample.ready;
	assign out_fire       = result.valid && result.ready;
	assign cfg.ready      = 1'b1;
	assign cfg_fire       = cfg.valid && cfg.ready;
	assign result.valid   = res_valid_q;
	assign result.drive   = res_drive_q;
	assign result.updated = res_updated_q;
	assign res_load       = (state_q == ST_DONE) && (!res_valid_q || out_fire);

	assign elapsed_in = sample.now_ms - prev_time_q;
	assign step_in    = elapsed_in > TW'(STEP_MS);

	// Pick operands for the current operation
	logic signed [DW:0] a_sel;
	logic signed [MB:0] b_sel;
	logic [MA-1:0]      a_mag;
	logic [MB:0]        b_mag_w;
	logic [MB-1:0]      b_mag;
	logic               op_neg, div_op;
	logic [TW-1:0]      den;

	always_comb begin
		case (op_q)
			OP_P: begin
				a_sel = err_q;
				b_sel = {{(MB+1-DW){prop_gain_q[DW-1]}}, prop_gain_q};
			end
			OP_I1: begin
				a_sel = err_q;
				b_sel = {{(MB+1-DW){integ_gain_q[DW-1]}}, integ_gain_q};
			end
			OP_I2: begin
				a_sel = {inc_q[DW-1], inc_q};
				b_sel = (MB+1)'(elapsed_q);
			end
			OP_D1: begin
				a_sel = diff_q;
				b_sel = {{(MB+1-DW){deriv_gain_q[DW-1]}}, deriv_gain_q};
			end
			OP_D2: begin
				a_sel = {d_q[DW-1], d_q};
				b_sel = (MB+1)'(MS_PER_S);
			end
			default: begin
				a_sel = '0;
				b_sel = '0;
			end
		endcase
	end

	assign a_mag   = a_sel[DW] ? -a_sel : a_sel;
	assign b_mag_w = b_sel[MB] ? -b_sel : b_sel;
	assign b_mag   = b_mag_w[MB-1:0];
	assign op_neg  = a_sel[DW] ^ b_sel[MB];
	assign div_op  = (op_q == OP_I2) || (op_q == OP_D2);
	assign den     = (op_q == OP_D2) ? elapsed_q : TW'(MS_PER_S);

	// Shift-add multiplier step
	logic [MA:0]   add_sum;
	logic [PW-1:0] prod_next;
	logic          ovf_chk;

	assign add_sum   = {1'b0, prod_q[PW-1:MB]} + (prod_q[0] ? {1'b0, mca_q} : '0);
	assign prod_next = {add_sum, prod_q[MB-1:1]};
	assign ovf_chk   = prod_next[PW-1:DW] >= (MB+1)'(den);

	// Restoring divider step
	logic [TW:0] div_t, div_sub;
	logic        div_ge;

	assign div_t   = {rem_q, quo_q[DW-1]};
	assign div_sub = div_t - {1'b0, den};
	assign div_ge  = div_t >= {1'b0, den};

	// Saturate the unit's magnitude and apply the sign
	logic [PW-1:0]        mag_sh;
	logic [DW-1:0]        lim, mag_dw;
	logic                 over;
	logic signed [DW-1:0] op_res;

	assign mag_sh = prod_q >> FW;
	assign lim    = neg_q ? DMIN : DMAX;
	assign over   = div_op ? (ovf_q || (quo_q > lim)) : (mag_sh > {{(PW-DW){1'b0}}, lim});
	assign mag_dw = div_op ? quo_q : mag_sh[DW-1:0];
	assign op_res = over ? (neg_q ? DMIN : DMAX) : (neg_q ? -mag_dw : mag_dw);

	// Integrator update: saturate, then clamp with the low bound first
	logic signed [DW:0]   isum;
	logic signed [DW-1:0] isat, integ_next;

	assign isum = {integ_q[DW-1], integ_q} + {inc_q[DW-1], inc_q};
	assign isat = (isum[DW] != isum[DW-1]) ? (isum[DW] ? DMIN : DMAX) : isum[DW-1:0];

	always_comb begin
		if (isat < integ_low_q) begin
			integ_next = integ_low_q;
		end else if (isat > integ_high_q) begin
			integ_next = integ_high_q;
		end else begin
			integ_next = isat;
		end
	end

	// Output sum: saturate, then clamp with the low bound first
	logic signed [DW+1:0] ssum;
	logic signed [DW-1:0] ssat, drive_next;

	assign ssum = {{2{p_q[DW-1]}}, p_q} + {{2{integ_q[DW-1]}}, integ_q}
		+ {{2{d_q[DW-1]}}, d_q};
	assign ssat = ((ssum[DW+1:DW-1] == 3'b000) || (ssum[DW+1:DW-1] == 3'b111))
		? ssum[DW-1:0] : (ssum[DW+1] ? DMIN : DMAX);

	always_comb begin
		if (ssat < out_low_q) begin
			drive_next = out_low_q;
		end else if (ssat > out_high_q) begin
			drive_next = out_high_q;
		end else begin
			drive_next = ssat;
		end
	end

	// Sequencer, configuration and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			op_q          <= OP_P;
			cnt_q         <= '0;
			res_valid_q   <= 1'b0;
			prop_gain_q   <= '0;
			integ_gain_q  <= '0;
			deriv_gain_q  <= '0;
			out_low_q     <= DMIN;
			out_high_q    <= DMAX;
			integ_low_q   <= DMIN;
			integ_high_q  <= DMAX;
			integ_q       <= '0;
			prev_meas_q   <= '0;
			prev_time_q   <= '0;
			primed_q      <= 1'b0;
			held_q        <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (step_in) begin
							prev_time_q <= sample.now_ms;
							prev_meas_q <= sample.measured;
							op_q        <= OP_P;
							state_q     <= ST_LOAD;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_LOAD: begin
					cnt_q   <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (cnt_q == CW'(MB - 1)) begin
						cnt_q   <= '0;
						state_q <= (div_op && !ovf_chk) ? ST_DIV : ST_FIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(DW - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// advance to the next product, skipping the derivative on the first step
					case (op_q)
						OP_P: begin
							op_q    <= OP_I1;
							state_q <= ST_LOAD;
						end
						OP_I1: begin
							op_q    <= OP_I2;
							state_q <= ST_LOAD;
						end
						OP_I2: begin
							op_q    <= OP_D1;
							state_q <= primed_q ? ST_LOAD : ST_INTEG;
						end
						OP_D1: begin
							op_q    <= OP_D2;
							state_q <= ST_LOAD;
						end
						default: begin
							state_q <= ST_INTEG;
						end
					endcase
				end
				ST_INTEG: begin
					integ_q <= integ_next;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					primed_q <= 1'b1;
					state_q  <= ST_DONE;
				end
				ST_DONE: begin
					if (res_load) begin
						if (fin_updated_q) begin
							held_q <= fin_drive_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// hold the result word until it is taken
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (out_fire) begin
				res_valid_q <= 1'b0;
			end

			// register writes; the preload also loads the integrator
			if (cfg_fire) begin
				case (cfg.index)
					REG_PROP_GAIN:   prop_gain_q  <= cfg.data;
					REG_INTEG_GAIN:  integ_gain_q <= cfg.data;
					REG_DERIV_GAIN:  deriv_gain_q <= cfg.data;
					REG_OUT_LOW:     out_low_q    <= cfg.data;
					REG_OUT_HIGH:    out_high_q   <= cfg.data;
					REG_INTEG_LOW:   integ_low_q  <= cfg.data;
					REG_INTEG_HIGH:  integ_high_q <= cfg.data;
					REG_INTEG_START: integ_q      <= cfg.data;
					default: begin
					end
				endcase
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					err_q     <= {sample.setpoint[DW-1], sample.setpoint}
						- {sample.measured[DW-1], sample.measured};
					diff_q    <= {prev_meas_q[DW-1], prev_meas_q}
						- {sample.measured[DW-1], sample.measured};
					elapsed_q <= elapsed_in;
					d_q       <= '0;
					// a held sample repeats the last drive
					fin_drive_q   <= held_q;
					fin_updated_q <= 1'b0;
				end
			end
			ST_LOAD: begin
				mca_q  <= a_mag;
				prod_q <= {{MA{1'b0}}, b_mag};
				neg_q  <= op_neg;
			end
			ST_MUL: begin
				prod_q <= prod_next;
				if (cnt_q == CW'(MB - 1)) begin
					ovf_q <= div_op && ovf_chk;
					rem_q <= prod_next[DW+TW-1:DW];
					quo_q <= prod_next[DW-1:0];
				end
			end
			ST_DIV: begin
				rem_q <= div_ge ? div_sub[TW-1:0] : div_t[TW-1:0];
				quo_q <= {quo_q[DW-2:0], div_ge};
			end
			ST_FIN: begin
				case (op_q)
					OP_P:                p_q   <= op_res;
					OP_I1, OP_I2:        inc_q <= op_res;
					OP_D1, OP_D2:        d_q   <= op_res;
					default: begin
					end
				endcase
			end
			ST_SUM: begin
				fin_drive_q   <= drive_next;
				fin_updated_q <= 1'b1;
			end
			default: begin
			end
		endcase

		if (res_load) begin
			res_drive_q   <= fin_drive_q;
			res_updated_q <= fin_updated_q;
		end
	end

	// Checks
	`PCC_ASSERT_NOW(a_div_rem_below_den, clk, arst_n, state_q == ST_DIV, rem_q < den,
		"divider remainder not below divisor")
	`PCC_ASSERT_NOW(a_held_drive, clk, arst_n, result.valid && !result.updated,
		result.drive == held_q, "held result differs from last drive")
	`PCC_ASSERT_NEXT(a_held_fast, clk, arst_n, in_fire && !step_in, state_q == ST_DONE,
		"held sample did not bypass the step")

endmodule

`default_nettype wire

/* verif/pid_controller_clamped_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for the clamped PID controller: drives samples and register writes,
// predicts each drive word in fixed point and compares it against the result channel.
// Depends on pcc_pkg, pcc_channels.sv and the pid_controller_clamped top level.

module pid_controller_clamped_tb import pcc_pkg::*;;

	localparam int     DW             = DATA_WIDTH_DEF;
	localparam int     FB             = FRAC_BITS_DEF;
	localparam longint WORD_MAX       = (longint'(1) <<< (DW - 1)) - 1;
	localparam longint WORD_MIN       = -WORD_MAX - 1;
	localparam longint ONE            = longint'(1) <<< FB;
	localparam int     WATCHDOG_LIMIT = 20000;
	localparam int     DRAIN_CYCLES   = 300;
	localparam int     HOLD_CYCLES    = 1200;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_INTEG_START + 1;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;

	typedef struct packed {
		logic signed [DW-1:0]         setpoint;
		logic signed [DW-1:0]         measured;
		logic        [TIME_WIDTH-1:0] now_ms;
	} sample_word_t;

	typedef struct packed {
		logic signed [DW-1:0] drive;
		logic                 updated;
	} drive_word_t;

	logic clk;
	logic arst_n;

	pcc_sample_if sample_ch ();
	pcc_result_if result_ch ();
	pcc_cfg_if    cfg_ch ();

	pid_controller_clamped dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// Controller registers as the predictor sees them
	longint kp = 0, ki = 0, kd = 0;
	longint drive_lo = WORD_MIN, drive_hi = WORD_MAX;
	longint integ_lo = WORD_MIN, integ_hi = WORD_MAX;

	// Controller state
	longint                  ctl_integ = 0;
	longint                  ctl_prev_meas = 0;
	logic   [TIME_WIDTH-1:0] ctl_prev_ms = '0;
	logic                    ctl_primed = 1'b0;
	longint                  ctl_held = 0;

	sample_word_t pending_samples[$];
	drive_word_t  expected_drive[$];
	int           samples_queued = 0;
	int           samples_taken = 0;
	int           fails = 0;
	int           quiet_cycles = 0;
	logic         sample_took = 1'b0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int stall_req = 0;
	int stall_seen = 0;
	int hold_left = 0;

	// Stimulus tracking state
	longint                  track_sp = 0;
	longint                  track_meas = 0;
	logic   [TIME_WIDTH-1:0] stamp_ms = '0;
	int                      run_left = 0;

	function automatic longint sat_word(input longint v);
		if (v > WORD_MAX) return WORD_MAX;
		if (v < WORD_MIN) return WORD_MIN;
		return v;
	endfunction

	// Low bound is tested first, so with crossed bounds a value below the low one gets it and any other the high one
	function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// Exact a*b / (2^sh * den), truncated toward zero, saturated to the word range
	function automatic longint scaled_product(input longint a, input longint b,
			input int unsigned sh, input longint unsigned den);
		logic [127:0] mag;
		logic [63:0]  ua, ub, lim;
		logic         neg;
		neg = (a < 0) != (b < 0);
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		mag = {64'b0, ua} * {64'b0, ub};
		mag = (mag >> sh) / ((den == 0) ? 128'd1 : {64'b0, den});
		lim = neg ? 64'(WORD_MAX) + 64'd1 : 64'(WORD_MAX);
		if (mag > {64'b0, lim}) return neg ? WORD_MIN : WORD_MAX;
		return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
	endfunction

	// Advance the controller by one sample and return the drive word it yields
	function automatic drive_word_t predict_drive(input longint sp, input longint ms,
			input logic [TIME_WIDTH-1:0] now);
		drive_word_t             r;
		logic [TIME_WIDTH-1:0]   gap;
		longint                  err, p_term, i_step, d_term;
		gap = now - ctl_prev_ms;
		if (gap <= STEP_MS) begin
			r.drive = DW'(ctl_held);
			r.updated = 1'b0;
			return r;
		end
		ctl_prev_ms = now;
		err = sp - ms;
		p_term = scaled_product(err, kp, FB, 1);
		i_step = scaled_product(scaled_product(err, ki, FB, 1), longint'(gap), 0, MS_PER_S);
		ctl_integ = clamp_to(sat_word(ctl_integ + i_step), integ_lo, integ_hi);
		if (ctl_primed)
			d_term = scaled_product(scaled_product(ctl_prev_meas - ms, kd, FB, 1),
				MS_PER_S, 0, longint'(gap));
		else
			d_term = 0;
		ctl_primed = 1'b1;
		ctl_prev_meas = ms;
		ctl_held = clamp_to(sat_word(p_term + ctl_integ + d_term), drive_lo, drive_hi);
		r.drive = DW'(ctl_held);
		r.updated = 1'b1;
		return r;
	endfunction

	function automatic longint signed_upto(input longint m);
		longint v;
		v = longint'($urandom_range(m, 0));
		return $urandom_range(1, 0) ? -v : v;
	endfunction

	// Mostly moderate levels, some full-range words, some corner values
	function automatic longint pick_level();
		int unsigned roll;
		roll = $urandom_range(99, 0);
		if (roll < 55) return signed_upto(100 * ONE);
		if (roll < 80) return longint'(int'($urandom));
		case ($urandom_range(3, 0))
			0: return WORD_MIN;
			1: return WORD_MAX;
			2: return 0;
			default: return -1;
		endcase
	endfunction

	task automatic push_sample(input longint sp, input longint ms,
			input logic [TIME_WIDTH-1:0] now);
		sample_word_t w;
		w.setpoint = DW'(sp);
		w.measured = DW'(ms);
		w.now_ms = now;
		pending_samples.push_back(w);
		samples_queued++;
	endtask

	// Write one register and mirror it into the predictor
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DW-1:0] value);
		longint v;
		v = longint'($signed(value));
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_PROP_GAIN:   kp = v;
			REG_INTEG_GAIN:  ki = v;
			REG_DERIV_GAIN:  kd = v;
			REG_OUT_LOW:     drive_lo = v;
			REG_OUT_HIGH:    drive_hi = v;
			REG_INTEG_LOW:   integ_lo = v;
			REG_INTEG_HIGH:  integ_hi = v;
			REG_INTEG_START: ctl_integ = v;
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Wait until every queued sample has been taken and answered
	task automatic settle();
		while (samples_taken != samples_queued || expected_drive.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic load_random_gains();
		write_reg(REG_PROP_GAIN, DW'(signed_upto(4 * ONE)));
		write_reg(REG_INTEG_GAIN, DW'(signed_upto(2 * ONE)));
		write_reg(REG_DERIV_GAIN, DW'(signed_upto(ONE / 2)));
		write_reg(REG_OUT_LOW, DW'(-longint'($urandom_range(2000 * ONE, ONE))));
		write_reg(REG_OUT_HIGH, DW'($urandom_range(2000 * ONE, ONE)));
		write_reg(REG_INTEG_LOW, DW'(-longint'($urandom_range(500 * ONE, 0))));
		write_reg(REG_INTEG_HIGH, DW'($urandom_range(500 * ONE, 0)));
		write_reg(REG_INTEG_START, ($urandom_range(3, 0) == 0) ?
			DW'($urandom) : DW'(signed_upto(50 * ONE)));
	endtask

	// Tracking runs: the measurement chases a held setpoint, with some noise words mixed in
	task automatic queue_track(input int count);
		longint      sp, ms;
		int unsigned roll;
		for (int k = 0; k < count; k++) begin
			if (run_left == 0) begin
				run_left = $urandom_range(30, 5);
				track_sp = pick_level();
			end
			run_left--;
			roll = $urandom_range(99, 0);
			if (roll < 80) begin
				track_meas = sat_word(track_meas + (track_sp - track_meas) / 4 +
					signed_upto(ONE));
				sp = track_sp;
				ms = track_meas;
			end else begin
				sp = pick_level();
				ms = pick_level();
			end
			roll = $urandom_range(99, 0);
			if (roll < 60) stamp_ms += $urandom_range(300, 11);
			else if (roll < 85) stamp_ms += $urandom_range(10, 0);
			else if (roll < 93) stamp_ms += $urandom_range(11, 10);
			else stamp_ms = $urandom;
			push_sample(sp, ms, stamp_ms);
		end
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Sample driver: offer the next pending word once the current one is gone
	always @(negedge clk) begin : feed_samples
		sample_word_t w;
		logic         give;
		if (!arst_n) begin
			sample_ch.valid <= 1'b0;
		end else if (!sample_ch.valid || sample_took) begin
			give = (pending_samples.size() != 0) && ($urandom_range(99, 0) >= send_idle_pct);
			if (give) begin
				w = pending_samples.pop_front();
				sample_ch.setpoint <= w.setpoint;
				sample_ch.measured <= w.measured;
				sample_ch.now_ms <= w.now_ms;
			end
			sample_ch.valid <= give;
		end
	end

	// Result ready: random back-pressure, plus a long hold-off on request
	always @(negedge clk) begin : pace_results
		if (stall_seen != stall_req) begin
			stall_seen = stall_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
		end
	end

	// Monitor: check results, predict accepted samples, watch for a hang
	always @(posedge clk) begin : watch_channels
		drive_word_t want;
		logic        res_took, any_took;
		sample_took = arst_n && sample_ch.valid && sample_ch.ready;
		res_took = arst_n && result_ch.valid && result_ch.ready;
		any_took = sample_took || res_took || (arst_n && cfg_ch.valid && cfg_ch.ready);
		if (res_took) begin
			if (expected_drive.size() == 0) begin
				$error("result with nothing pending: drive %0d updated %0b",
					result_ch.drive, result_ch.updated);
				fails++;
			end else begin
				want = expected_drive.pop_front();
				if (result_ch.drive !== want.drive) begin
					$error("drive: expected %0d, got %0d", want.drive, result_ch.drive);
					fails++;
				end
				if (result_ch.updated !== want.updated) begin
					$error("updated: expected %0b, got %0b", want.updated, result_ch.updated);
					fails++;
				end
			end
		end
		if (sample_took) begin
			expected_drive.push_back(predict_drive(longint'(sample_ch.setpoint),
				longint'(sample_ch.measured), sample_ch.now_ms));
			samples_taken++;
		end
		quiet_cycles = any_took ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin : run_test
		arst_n = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.setpoint = '0;
		sample_ch.measured = '0;
		sample_ch.now_ms = '0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Sender mostly busy, receiver mostly stalling
		send_idle_pct = 8;
		recv_idle_pct = 82;

		// Directed: held windows, first step, field extremes, timestamp wrap
		write_reg(REG_PROP_GAIN, DW'(3 * ONE / 2));
		write_reg(REG_INTEG_GAIN, DW'(ONE / 2));
		write_reg(REG_DERIV_GAIN, DW'(ONE / 4));
		write_reg(REG_INTEG_START, DW'(2 * ONE));
		push_sample(10 * ONE, 2 * ONE, 32'd0);
		push_sample(10 * ONE, 2 * ONE, 32'd10);
		push_sample(10 * ONE, 2 * ONE, 32'd11);
		push_sample(10 * ONE, 4 * ONE, 32'd21);
		push_sample(10 * ONE, 5 * ONE, 32'd22);
		push_sample(WORD_MAX, WORD_MIN, 32'd100);
		push_sample(WORD_MIN, WORD_MAX, 32'd200);
		push_sample(WORD_MIN, WORD_MIN, 32'd300);
		push_sample(WORD_MAX, WORD_MAX, 32'hFFFF_FFFF);
		push_sample(-ONE, 0, 32'd9);
		push_sample(-1, 0, 32'd10);
		push_sample(0, -1, 32'd21);
		push_sample(0, -1, 32'd32);
		push_sample(0, -1, 32'd32);
		push_sample(WORD_MAX, 0, 32'd5000);
		push_sample(0, WORD_MIN, 32'd5011);
		stamp_ms = 32'd5011;
		settle();

		load_random_gains();
		queue_track(250);
		settle();

		// Full-scale gains, preload at the top of the range, writes to spare indexes
		write_reg(REG_PROP_GAIN, DW'(WORD_MAX));
		write_reg(REG_INTEG_GAIN, DW'(WORD_MIN));
		write_reg(REG_DERIV_GAIN, DW'(WORD_MIN));
		write_reg(REG_OUT_LOW, DW'(WORD_MIN));
		write_reg(REG_OUT_HIGH, DW'(WORD_MAX));
		write_reg(REG_INTEG_LOW, DW'(WORD_MIN));
		write_reg(REG_INTEG_HIGH, DW'(WORD_MAX));
		write_reg(REG_INTEG_START, DW'(WORD_MAX));
		write_reg(REG_SPARE_FIRST, DW'($urandom));
		write_reg(REG_SPARE_LAST, DW'($urandom));
		queue_track(80);
		settle();

		load_random_gains();
		queue_track(150);
		settle();

		// Sender mostly idle, receiver mostly ready
		send_idle_pct = 82;
		recv_idle_pct = 8;
		load_random_gains();
		queue_track(250);
		settle();

		// Crossed bounds on both clamps, preload at the bottom of the range
		write_reg(REG_PROP_GAIN, DW'(WORD_MIN));
		write_reg(REG_INTEG_GAIN, DW'(WORD_MAX));
		write_reg(REG_DERIV_GAIN, DW'(WORD_MAX));
		write_reg(REG_OUT_LOW, DW'(5 * ONE));
		write_reg(REG_OUT_HIGH, DW'(-5 * ONE));
		write_reg(REG_INTEG_LOW, DW'(ONE));
		write_reg(REG_INTEG_HIGH, DW'(-ONE));
		write_reg(REG_INTEG_START, DW'(WORD_MIN));
		queue_track(60);
		settle();

		load_random_gains();
		queue_track(150);
		settle();

		// No idling; hold the result side off so the sample side backs up
		send_idle_pct = 0;
		recv_idle_pct = 0;
		load_random_gains();
		stall_req++;
		queue_track(40);
		settle();

		load_random_gains();
		queue_track(250);
		settle();

		load_random_gains();
		queue_track(190);
		settle();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
